>>> sv/tfs_pkg.sv
// Shared constants, types and helper functions for the flat triangle shader.
// Depends on nothing; every other file of the block uses it.
package tfs_pkg;

	localparam int COORD_BITS_DEF      = 24;
	localparam int SHADE_FRAC_BITS_DEF = 10;

	localparam int EDGE_W    = 26;
	localparam int NMAG_W    = 51;
	localparam int MAG_W     = 30;
	localparam int SQ_W      = 62;
	localparam int ROOT_W    = 31;
	localparam int UNIT_BITS = 14;
	localparam int UNIT_W    = 16;
	localparam int QUO_W     = 15;

	localparam int LIGHT_X = -5742;
	localparam int LIGHT_Y = 13452;
	localparam int LIGHT_Z = -7382;

	localparam int PCT_BASE = 62;
	localparam int PCT_KD   = 28;
	localparam int PCT_KT   = 10;
	localparam int PCT_KU   = 8;
	localparam int PCT_LO   = 50;
	localparam int PCT_HI   = 110;

	typedef struct packed {
		logic [31:0]                 color;
		logic [2:0]                  neg;
		logic [2:0][MAG_W-1:0]       mag;
	} norm_t;

	typedef struct packed {
		logic [31:0]                 color;
		logic [2:0][UNIT_W-1:0]      unit;
	} unit_t;

	function automatic int round_pct(int pct, int frac);
		return (pct * (1 << frac) + 50) / 100;
	endfunction

endpackage

>>> sv/tfs_normal.sv
// Edge vectors, cross product, scaling and squared length of the face normal.
// Seven register stages; uses tfs_pkg.
module tfs_normal #(
	parameter int COORD_BITS = tfs_pkg::COORD_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  logic                             in_valid,
	input  logic [2:0][COORD_BITS-1:0]       va,
	input  logic [2:0][COORD_BITS-1:0]       vb,
	input  logic [2:0][COORD_BITS-1:0]       vc,
	input  logic [31:0]                      color,
	output logic                             out_valid,
	output tfs_pkg::norm_t                   norm,
	output logic [tfs_pkg::SQ_W-1:0]         len2
);

	localparam int EW     = COORD_BITS + 1;
	localparam int EDW    = tfs_pkg::EDGE_W;
	localparam int MW     = tfs_pkg::MAG_W;
	localparam int NW     = tfs_pkg::NMAG_W;
	localparam int ES_MAX = (EW > EDW - 1) ? EW - (EDW - 1) : 0;
	localparam int ES_W   = (ES_MAX > 0) ? $clog2(ES_MAX + 1) : 1;
	localparam int NS_MAX = NW - MW;
	localparam int NS_W   = $clog2(NS_MAX + 1);

	logic [6:0]                  vld_s;
	logic [5:0][EW-1:0]          e_s1;
	logic [5:0][EDW-1:0]         e_s2;
	logic [5:0][2*EDW-1:0]       p_s3;
	logic [2:0][2*EDW:0]         n_s4;
	logic [2:0][MW-1:0]          m_s5, m_s6, m_s7;
	logic [2:0]                  neg_s5, neg_s6, neg_s7;
	logic [2:0][2*MW-1:0]        sq_s6;
	logic [tfs_pkg::SQ_W-1:0]    len2_s7;
	logic [31:0]                 col_s1, col_s2, col_s3, col_s4, col_s5, col_s6, col_s7;

	logic [5:0][EW-1:0]          e_d;
	logic [5:0][EDW-1:0]         esh_d;
	logic [5:0][2*EDW-1:0]       p_d;
	logic [2:0][2*EDW:0]         n_d;
	logic [2:0][MW-1:0]          m_d;
	logic [2:0]                  neg_d;
	logic [2:0][2*MW-1:0]        sq_d;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			e_d[i]     = {vb[i][COORD_BITS-1], vb[i]} - {va[i][COORD_BITS-1], va[i]};
			e_d[3 + i] = {vc[i][COORD_BITS-1], vc[i]} - {va[i][COORD_BITS-1], va[i]};
		end
	end

	always_comb begin
		logic [5:0][EW-1:0] emag;
		logic [EW-1:0]      mor;
		logic [ES_W-1:0]    es;
		logic [EDW-1:0]     mg;
		mor = '0;
		for (int i = 0; i < 6; i++) begin
			emag[i] = e_s1[i][EW-1] ? (~e_s1[i] + 1'b1) : e_s1[i];
			mor     = mor | emag[i];
		end
		es = '0;
		for (int k = 0; k < ES_MAX; k++) begin
			if ((64'(mor) >> k) >= (64'd1 << (EDW - 1))) begin
				es = ES_W'(k + 1);
			end
		end
		for (int i = 0; i < 6; i++) begin
			mg       = EDW'(emag[i] >> es);
			esh_d[i] = e_s1[i][EW-1] ? (~mg + 1'b1) : mg;
		end
	end

	always_comb begin
		p_d[0] = $signed(e_s2[1]) * $signed(e_s2[5]);
		p_d[1] = $signed(e_s2[2]) * $signed(e_s2[4]);
		p_d[2] = $signed(e_s2[2]) * $signed(e_s2[3]);
		p_d[3] = $signed(e_s2[0]) * $signed(e_s2[5]);
		p_d[4] = $signed(e_s2[0]) * $signed(e_s2[4]);
		p_d[5] = $signed(e_s2[1]) * $signed(e_s2[3]);
		for (int i = 0; i < 3; i++) begin
			n_d[i] = {p_s3[2*i][2*EDW-1], p_s3[2*i]} - {p_s3[2*i+1][2*EDW-1], p_s3[2*i+1]};
		end
	end

	always_comb begin
		logic [2:0][2*EDW:0] nabs;
		logic [NW-1:0]       nor_v;
		logic [NS_W-1:0]     ns;
		nor_v = '0;
		for (int i = 0; i < 3; i++) begin
			nabs[i]  = n_s4[i][2*EDW] ? (~n_s4[i] + 1'b1) : n_s4[i];
			neg_d[i] = n_s4[i][2*EDW];
			nor_v    = nor_v | nabs[i][NW-1:0];
		end
		ns = '0;
		for (int k = 0; k < NS_MAX; k++) begin
			if ((nor_v >> k) >= (NW'(1) << MW)) begin
				ns = NS_W'(k + 1);
			end
		end
		for (int i = 0; i < 3; i++) begin
			m_d[i] = MW'(nabs[i][NW-1:0] >> ns);
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sq_d[i] = {{MW{1'b0}}, m_s5[i]} * {{MW{1'b0}}, m_s5[i]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[5:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e_s1    <= e_d;
			col_s1  <= color;
			e_s2    <= esh_d;
			col_s2  <= col_s1;
			p_s3    <= p_d;
			col_s3  <= col_s2;
			n_s4    <= n_d;
			col_s4  <= col_s3;
			m_s5    <= m_d;
			neg_s5  <= neg_d;
			col_s5  <= col_s4;
			sq_s6   <= sq_d;
			m_s6    <= m_s5;
			neg_s6  <= neg_s5;
			col_s6  <= col_s5;
			len2_s7 <= tfs_pkg::SQ_W'(sq_s6[0]) + tfs_pkg::SQ_W'(sq_s6[1])
			           + tfs_pkg::SQ_W'(sq_s6[2]);
			m_s7    <= m_s6;
			neg_s7  <= neg_s6;
			col_s7  <= col_s6;
		end
	end

	assign out_valid  = vld_s[6];
	assign len2       = len2_s7;
	assign norm.color = col_s7;
	assign norm.neg   = neg_s7;
	assign norm.mag   = m_s7;

endmodule

>>> sv/tfs_isqrt.sv
// Pipelined integer square root, two result bits per stage.
// Carries the normal side data alongside; uses tfs_pkg.
module tfs_isqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [tfs_pkg::SQ_W-1:0]    rad,
	input  tfs_pkg::norm_t              side_in,
	output logic                        out_valid,
	output logic [tfs_pkg::ROOT_W-1:0]  root,
	output tfs_pkg::norm_t              side_out
);

	localparam int RW    = tfs_pkg::ROOT_W;
	localparam int XW    = tfs_pkg::SQ_W;
	localparam int STEPS = RW;
	localparam int PER   = 2;
	localparam int NST   = (STEPS + PER - 1) / PER;

	typedef struct packed {
		logic [RW+2:0]  rem;
		logic [RW-1:0]  root;
		logic [XW-1:0]  rad;
	} sq_t;

	function automatic sq_t sq_step(sq_t a);
		sq_t           r;
		logic [RW+2:0] cur;
		logic [RW+2:0] trial;
		cur   = {a.rem[RW:0], a.rad[XW-1 -: 2]};
		trial = {1'b0, a.root, 2'b01};
		if (cur >= trial) begin
			r.rem  = cur - trial;
			r.root = {a.root[RW-2:0], 1'b1};
		end else begin
			r.rem  = cur;
			r.root = {a.root[RW-2:0], 1'b0};
		end
		r.rad = {a.rad[XW-3:0], 2'b00};
		return r;
	endfunction

	function automatic sq_t sq_steps(sq_t a, int k);
		sq_t r;
		r = a;
		for (int j = 0; j < PER; j++) begin
			if (k * PER + j < STEPS) begin
				r = sq_step(r);
			end
		end
		return r;
	endfunction

	sq_t             init;
	sq_t             nxt     [NST];
	sq_t             pipe_s  [NST];
	tfs_pkg::norm_t  side_s  [NST];
	logic [NST-1:0]  vld_s;

	assign init.rem  = '0;
	assign init.root = '0;
	assign init.rad  = rad;

	always_comb begin
		nxt[0] = sq_steps(init, 0);
		for (int k = 1; k < NST; k++) begin
			nxt[k] = sq_steps(pipe_s[k-1], k);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NST-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= side_in;
			for (int k = 0; k < NST; k++) begin
				pipe_s[k] <= nxt[k];
			end
			for (int k = 1; k < NST; k++) begin
				side_s[k] <= side_s[k-1];
			end
		end
	end

	assign out_valid = vld_s[NST-1];
	assign root      = pipe_s[NST-1].root;
	assign side_out  = side_s[NST-1];

endmodule

>>> sv/tfs_div.sv
// Pipelined restoring divider that scales the normal to a Q1.14 unit vector.
// Three lanes share the root as divisor; uses tfs_pkg.
module tfs_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [tfs_pkg::ROOT_W-1:0]  len,
	input  tfs_pkg::norm_t              side,
	output logic                        out_valid,
	output tfs_pkg::unit_t              unit
);

	localparam int RW    = tfs_pkg::ROOT_W;
	localparam int QW    = tfs_pkg::QUO_W;
	localparam int UW    = tfs_pkg::UNIT_W;
	localparam int STEPS = QW;
	localparam int PER   = 2;
	localparam int NST   = (STEPS + PER - 1) / PER;

	typedef struct packed {
		logic [RW-1:0]         len;
		logic [31:0]           color;
		logic [2:0]            neg;
		logic [2:0][RW:0]      rem;
		logic [2:0][QW-1:0]    quo;
	} dv_t;

	function automatic dv_t dv_step(dv_t a, int idx);
		dv_t         r;
		logic [RW:0] cur;
		r = a;
		for (int i = 0; i < 3; i++) begin
			cur = (idx == 0) ? a.rem[i] : {a.rem[i][RW-1:0], 1'b0};
			if (cur >= {1'b0, a.len}) begin
				r.rem[i] = cur - {1'b0, a.len};
				r.quo[i] = {a.quo[i][QW-2:0], 1'b1};
			end else begin
				r.rem[i] = cur;
				r.quo[i] = {a.quo[i][QW-2:0], 1'b0};
			end
		end
		return r;
	endfunction

	function automatic dv_t dv_steps(dv_t a, int k);
		dv_t r;
		r = a;
		for (int j = 0; j < PER; j++) begin
			if (k * PER + j < STEPS) begin
				r = dv_step(r, k * PER + j);
			end
		end
		return r;
	endfunction

	dv_t                   init;
	dv_t                   nxt    [NST];
	dv_t                   pipe_s [NST];
	logic [NST-1:0]        vld_s;
	logic                  vld_s9;
	logic [2:0][UW-1:0]    unit_s9;
	logic [31:0]           col_s9;
	logic [2:0][UW-1:0]    unit_d;

	always_comb begin
		init.len   = len;
		init.color = side.color;
		init.neg   = side.neg;
		init.quo   = '0;
		for (int i = 0; i < 3; i++) begin
			init.rem[i] = (RW + 1)'(side.mag[i]);
		end
		nxt[0] = dv_steps(init, 0);
		for (int k = 1; k < NST; k++) begin
			nxt[k] = dv_steps(pipe_s[k-1], k);
		end
	end

	always_comb begin
		logic [UW-1:0] q;
		for (int i = 0; i < 3; i++) begin
			q = UW'(pipe_s[NST-1].quo[i]);
			if (pipe_s[NST-1].len == '0) begin
				unit_d[i] = '0;
			end else if (pipe_s[NST-1].neg[i]) begin
				unit_d[i] = ~q + 1'b1;
			end else begin
				unit_d[i] = q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s  <= '0;
			vld_s9 <= 1'b0;
		end else if (en) begin
			vld_s  <= {vld_s[NST-2:0], in_valid};
			vld_s9 <= vld_s[NST-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NST; k++) begin
				pipe_s[k] <= nxt[k];
			end
			unit_s9 <= unit_d;
			col_s9  <= pipe_s[NST-1].color;
		end
	end

	assign out_valid  = vld_s9;
	assign unit.unit  = unit_s9;
	assign unit.color = col_s9;

endmodule

>>> sv/tfs_shade.sv
// Light terms, shade factor and colour scaling from the unit normal.
// Five register stages; uses tfs_pkg.
module tfs_shade #(
	parameter int SHADE_FRAC_BITS = tfs_pkg::SHADE_FRAC_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  tfs_pkg::unit_t  unit,
	output logic            out_valid,
	output logic [8:0]      red,
	output logic [8:0]      green,
	output logic [8:0]      blue,
	output logic [7:0]      alpha,
	output logic [10:0]     shade
);

	localparam int F      = SHADE_FRAC_BITS;
	localparam int SW     = F + 1;
	localparam int UB     = tfs_pkg::UNIT_BITS;
	localparam int ACC_W  = 40;
	localparam int BASE   = tfs_pkg::round_pct(tfs_pkg::PCT_BASE, F);
	localparam int KD     = tfs_pkg::round_pct(tfs_pkg::PCT_KD, F);
	localparam int KT     = tfs_pkg::round_pct(tfs_pkg::PCT_KT, F);
	localparam int KU     = tfs_pkg::round_pct(tfs_pkg::PCT_KU, F);
	localparam int LO     = tfs_pkg::round_pct(tfs_pkg::PCT_LO, F);
	localparam int HI     = tfs_pkg::round_pct(tfs_pkg::PCT_HI, F);
	localparam longint BASE_SH = longint'(BASE) << UB;

	localparam logic signed [15:0] LX = 16'(tfs_pkg::LIGHT_X);
	localparam logic signed [15:0] LY = 16'(tfs_pkg::LIGHT_Y);
	localparam logic signed [15:0] LZ = 16'(tfs_pkg::LIGHT_Z);
	localparam logic [15:0] KD_C = 16'(KD);
	localparam logic [15:0] KT_C = 16'(KT);
	localparam logic [15:0] KU_C = 16'(KU);

	logic [4:0]          vld_s;
	logic [2:0][31:0]    dp_s1;
	logic [15:0]         uy_s1;
	logic [15:0]         d_s2;
	logic [14:0]         t_s2, u_s2;
	logic [31:0]         pd_s3, pt_s3, pu_s3;
	logic [SW-1:0]       shade_s4;
	logic [8:0]          red_s5, green_s5, blue_s5;
	logic [7:0]          alpha_s5;
	logic [10:0]         shade_s5;
	logic [31:0]         col_s1, col_s2, col_s3, col_s4;

	logic [2:0][31:0]    dp_d;
	logic [15:0]         d_d;
	logic [14:0]         t_d, u_d;
	logic [SW-1:0]       shade_d;

	always_comb begin
		dp_d[0] = $signed(unit.unit[0]) * LX;
		dp_d[1] = $signed(unit.unit[1]) * LY;
		dp_d[2] = $signed(unit.unit[2]) * LZ;
	end

	always_comb begin
		logic signed [32:0] dot;
		logic [32:0]        dpos;
		dot  = $signed({dp_s1[0][31], dp_s1[0]}) + $signed({dp_s1[1][31], dp_s1[1]})
		       + $signed({dp_s1[2][31], dp_s1[2]});
		dpos = dot[32] ? '0 : dot;
		d_d  = 16'(dpos >> UB);
		t_d  = uy_s1[15] ? '0 : uy_s1[14:0];
		u_d  = uy_s1[15] ? 15'(~uy_s1 + 1'b1) : '0;
	end

	always_comb begin
		logic signed [ACC_W-1:0] acc;
		logic [ACC_W-1:0]        shv;
		acc = ACC_W'(BASE_SH) + ACC_W'(pd_s3) + ACC_W'(pt_s3) - ACC_W'(pu_s3);
		shv = acc[ACC_W-1] ? '0 : (acc >> UB);
		if (shv < ACC_W'(LO)) begin
			shade_d = SW'(LO);
		end else if (shv > ACC_W'(HI)) begin
			shade_d = SW'(HI);
		end else begin
			shade_d = SW'(shv);
		end
	end

	function automatic logic [8:0] scale(logic [7:0] c, logic [SW-1:0] s);
		logic [F+8:0] pr;
		pr = (F + 9)'(c) * (F + 9)'(s);
		return 9'(pr >> F);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[3:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dp_s1    <= dp_d;
			uy_s1    <= unit.unit[1];
			col_s1   <= unit.color;
			d_s2     <= d_d;
			t_s2     <= t_d;
			u_s2     <= u_d;
			col_s2   <= col_s1;
			pd_s3    <= KD_C * d_s2;
			pt_s3    <= KT_C * 16'(t_s2);
			pu_s3    <= KU_C * 16'(u_s2);
			col_s3   <= col_s2;
			shade_s4 <= shade_d;
			col_s4   <= col_s3;
			red_s5   <= scale(col_s4[31:24], shade_s4);
			green_s5 <= scale(col_s4[23:16], shade_s4);
			blue_s5  <= scale(col_s4[15:8], shade_s4);
			alpha_s5 <= col_s4[7:0];
			shade_s5 <= 11'(shade_s4);
		end
	end

	assign out_valid = vld_s[4];
	assign red       = red_s5;
	assign green     = green_s5;
	assign blue      = blue_s5;
	assign alpha     = alpha_s5;
	assign shade     = shade_s5;

endmodule

>>> sv/triangle_flat_shade.sv
// Throughput: one word per clock; every stage advances together whenever the
// output register is empty or its word is being taken.
// Reset (arst_n low) clears only the valid bits of every stage.
// Top level of the flat triangle shader; instantiates tfs_normal, tfs_isqrt,
// tfs_div and tfs_shade and uses tfs_pkg.
module triangle_flat_shade #(
	parameter int COORD_BITS      = tfs_pkg::COORD_BITS_DEF,
	parameter int SHADE_FRAC_BITS = tfs_pkg::SHADE_FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          vtx_valid,
	output logic                          vtx_stall,
	input  logic signed [COORD_BITS-1:0]  a_x,
	input  logic signed [COORD_BITS-1:0]  a_y,
	input  logic signed [COORD_BITS-1:0]  a_z,
	input  logic signed [COORD_BITS-1:0]  b_x,
	input  logic signed [COORD_BITS-1:0]  b_y,
	input  logic signed [COORD_BITS-1:0]  b_z,
	input  logic signed [COORD_BITS-1:0]  c_x,
	input  logic signed [COORD_BITS-1:0]  c_y,
	input  logic signed [COORD_BITS-1:0]  c_z,
	input  logic [31:0]                   color_rgba,
	output logic                          pix_valid,
	input  logic                          pix_stall,
	output logic [8:0]                    shaded_red,
	output logic [8:0]                    shaded_green,
	output logic [8:0]                    shaded_blue,
	output logic [7:0]                    alpha_out,
	output logic [10:0]                   shade_factor
);

	logic                                 adv;
	logic [2:0][COORD_BITS-1:0]           va, vb, vc;
	logic                                 nrm_valid, sqr_valid, div_valid;
	tfs_pkg::norm_t                       nrm_side, sqr_side;
	logic [tfs_pkg::SQ_W-1:0]             len2;
	logic [tfs_pkg::ROOT_W-1:0]           root;
	tfs_pkg::unit_t                       unit;

	assign adv       = !(pix_valid && pix_stall);
	assign vtx_stall = !adv;

	assign va = {a_z, a_y, a_x};
	assign vb = {b_z, b_y, b_x};
	assign vc = {c_z, c_y, c_x};

	tfs_normal #(
		.COORD_BITS(COORD_BITS)
	) u_normal (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (vtx_valid),
		.va        (va),
		.vb        (vb),
		.vc        (vc),
		.color     (color_rgba),
		.out_valid (nrm_valid),
		.norm      (nrm_side),
		.len2      (len2)
	);

	tfs_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (nrm_valid),
		.rad       (len2),
		.side_in   (nrm_side),
		.out_valid (sqr_valid),
		.root      (root),
		.side_out  (sqr_side)
	);

	tfs_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (sqr_valid),
		.len       (root),
		.side      (sqr_side),
		.out_valid (div_valid),
		.unit      (unit)
	);

	tfs_shade #(
		.SHADE_FRAC_BITS(SHADE_FRAC_BITS)
	) u_shade (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (div_valid),
		.unit      (unit),
		.out_valid (pix_valid),
		.red       (shaded_red),
		.green     (shaded_green),
		.blue      (shaded_blue),
		.alpha     (alpha_out),
		.shade     (shade_factor)
	);

`ifndef SYNTHESIS
	a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		vtx_stall |-> (pix_valid && pix_stall))
		else $error("input stalled while the output word is free");

	a_shade_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid |-> ((SHADE_FRAC_BITS > 10)
			|| ((shade_factor >= 11'(tfs_pkg::round_pct(tfs_pkg::PCT_LO, SHADE_FRAC_BITS)))
			&& (shade_factor <= 11'(tfs_pkg::round_pct(tfs_pkg::PCT_HI, SHADE_FRAC_BITS))))))
		else $error("shade factor outside its clamp range");

	a_red_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid |-> ((SHADE_FRAC_BITS != 10)
			|| (shaded_red <= 9'((255 * tfs_pkg::round_pct(tfs_pkg::PCT_HI, 10)) >> 10))))
		else $error("scaled red exceeds the largest possible value");
`endif

endmodule
